// ===== rtl/pfm_pkg.sv =====
package pfm_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_PPM         = 3'd0,
    CFG_RT_TOL      = 3'd1,
    CFG_PREC_ONLY   = 3'd2,
    CFG_MAX_PERSIST = 3'd3,
    CFG_MIN_MASS    = 3'd4,
    CFG_MAX_MASS    = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_CMP,
    ST_DUP,
    ST_FIN,
    ST_ORD,
    ST_OLD
  } state_e;

  localparam int unsigned MZ_W     = 30;
  localparam int unsigned RT_W     = 20;
  localparam int unsigned KEY_W    = 22;
  localparam int unsigned CFG_W    = 30;
  localparam logic [16:0] PROTON_FX = 17'd66013;
  localparam logic [29:0] MASS_MAX  = 30'h3FFF_FFFF;

  typedef struct packed {
    logic [29:0] base_peak;
    logic [29:0] mono;
    logic [3:0]  charge;
    logic [19:0] first_rt;
    logic [19:0] last_rt;
    logic [19:0] apex_rt;
    logic [31:0] apex_int;
    logic [31:0] total_int;
  } feat_t;

  typedef struct packed {
    logic [9:0]  ppm;
    logic [15:0] rt_tol;
    logic        prec_only;
  } match_cfg_t;

  // Lower wide-window offset: z * (proton - 0.05 Da).
  function automatic logic [19:0] lo_off(input logic [3:0] z);
    return 20'(z * 20'd62736);
  endfunction

  // Upper wide-window offset for charge z, proton included.
  function automatic logic [20:0] hi_off(input logic [3:0] z);
    logic [20:0] r;
    case (z)
      4'd1:         r = 21'd269175;
      4'd2:         r = 21'd407278;
      4'd3, 4'd4:   r = 21'(z * 21'd134826);
      default:      r = 21'(z * 21'd69290);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/pfm_if.sv =====
interface pfm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [29:0] feat_base_peak;
  logic [29:0] feat_mono_mass;
  logic [3:0]  feat_charge;
  logic [19:0] feat_first_rt;
  logic [19:0] feat_last_rt;
  logic [19:0] feat_apex_rt;
  logic [31:0] feat_apex_intensity;
  logic [31:0] feat_total_intensity;
  logic [29:0] scan_mz;
  logic [19:0] scan_rt;

  modport source (
    output valid, req_type, feat_base_peak, feat_mono_mass, feat_charge, feat_first_rt,
           feat_last_rt, feat_apex_rt, feat_apex_intensity, feat_total_intensity,
           scan_mz, scan_rt,
    input  ready
  );
  modport sink (
    input  valid, req_type, feat_base_peak, feat_mono_mass, feat_charge, feat_first_rt,
           feat_last_rt, feat_apex_rt, feat_apex_intensity, feat_total_intensity,
           scan_mz, scan_rt,
    output ready
  );
endinterface

interface pfm_res_if;
  logic        valid;
  logic        ready;
  logic [9:0]  hit_index;
  logic [3:0]  hit_charge;
  logic [29:0] hit_mh_mass;
  logic [19:0] hit_apex_rt;
  logic [31:0] hit_total_intensity;
  logic [4:0]  hit_count;
  logic        overflow;
  logic        last;

  modport source (
    output valid, hit_index, hit_charge, hit_mh_mass, hit_apex_rt, hit_total_intensity,
           hit_count, overflow, last,
    input  ready
  );
  modport sink (
    input  valid, hit_index, hit_charge, hit_mh_mass, hit_apex_rt, hit_total_intensity,
           hit_count, overflow, last,
    output ready
  );
endinterface

// ===== rtl/precursor_feature_matcher_core.sv =====
// Precursor feature matcher.
// The request channel carries clear, load and query items; the result channel
// returns one item per distinct hit of a query, or a single all-zero item with
// last set when nothing matched. Configuration writes land on the plain write
// port and must only happen while the block is idle.
// Clear and load produce no result. A query reads every stored feature through
// one registered table port and one shared match unit in states RD, EVAL and
// CMP, two passes unless precursor-only mode is set. Each match is then
// compared against the listed hits one at a time; a new hit is added while the
// list has room. The FIN state closes the list; each result is then read back
// from the table in states ORD and OLD and offered on the channel, where it
// waits while the receiver holds ready low. The result register keeps its item
// until it is taken. Request ready is high only in the idle state with no
// result waiting.
// Reset empties the table and loads the default configuration; table contents
// are not cleared and are never read before being written.
module precursor_feature_matcher_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned MAX_HITS    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pfm_req_if.sink           req_i,
  pfm_res_if.source         res_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [pfm_pkg::CFG_W-1:0] cfg_data_i
);
  import pfm_pkg::*;

  localparam int unsigned IW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HITS);
  localparam int unsigned HCW = $clog2(MAX_HITS + 1);

  state_e state_q, state_d;

  logic [9:0]  ppm_q;
  logic [15:0] rt_tol_q;
  logic        prec_only_q;
  logic [19:0] max_persist_q;
  logic [29:0] min_mass_q, max_mass_q;

  logic [CW-1:0]  count_q;
  logic [IW-1:0]  fi_q;
  logic           pass_q;
  logic [HCW-1:0] k_q, total_q;
  logic           ovf_q;
  logic [29:0]    scan_mz_q;
  logic [19:0]    scan_rt_q;

  feat_t       mem [TABLE_DEPTH];
  feat_t       feat_q;
  logic        mem_re;
  logic [IW-1:0] mem_raddr;

  logic [IW-1:0]    hl_idx   [MAX_HITS];
  logic [3:0]       hl_chg   [MAX_HITS];
  logic [KEY_W-1:0] hl_key   [MAX_HITS];
  logic [31:0]      hl_apex  [MAX_HITS];

  logic [9:0]  o_idx_q;
  logic [3:0]  o_chg_q;
  logic [29:0] o_mh_q;
  logic [19:0] o_apex_q;
  logic [31:0] o_tot_q;
  logic        o_last_q;
  logic        out_valid_q;

  match_cfg_t mcfg;
  logic       base_hit, wide_hit, hit;
  logic [KEY_W-1:0] key;

  logic req_acc, res_acc;
  logic scan_last, next_pass, load_ok;
  logic dup_end, dup_eq;
  logic [20:0] dur;
  logic [30:0] mh_full;

  assign mcfg = '{ppm: ppm_q, rt_tol: rt_tol_q, prec_only: prec_only_q};

  pfm_match_unit u_match (
    .clk_i      (clk_i),
    .en_i       (state_q == ST_EVAL),
    .feat_i     (feat_q),
    .mz_i       (scan_mz_q),
    .rt_i       (scan_rt_q),
    .cfg_i      (mcfg),
    .base_hit_o (base_hit),
    .wide_hit_o (wide_hit),
    .key_o      (key)
  );

  assign req_acc   = req_i.valid && req_i.ready;
  assign res_acc   = res_o.valid && res_o.ready;
  assign hit       = pass_q ? wide_hit : base_hit;
  assign scan_last = ((CW'(fi_q) + CW'(1)) == count_q);
  assign next_pass = !pass_q && !prec_only_q;
  assign dup_end   = (k_q == total_q);
  assign dup_eq    = (hl_chg[k_q[HW-1:0]] == feat_q.charge) &&
                     (hl_key[k_q[HW-1:0]] == key);
  // A negative duration always passes the persistence test.
  assign dur       = 21'(req_i.feat_last_rt) - 21'(req_i.feat_first_rt);
  assign load_ok   = (dur[20] || (dur[19:0] <= max_persist_q)) &&
                     (req_i.feat_mono_mass >= min_mass_q) &&
                     (req_i.feat_mono_mass <= max_mass_q) &&
                     (count_q < CW'(TABLE_DEPTH));
  assign mh_full   = 31'(feat_q.mono) + 31'(PROTON_FX);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc && req_i.req_type == REQ_QUERY) begin
          state_d = (count_q == '0) ? ST_FIN : ST_RD;
        end
      end
      ST_RD:   state_d = ST_EVAL;
      ST_EVAL: state_d = ST_CMP;
      ST_CMP: begin
        if (hit) begin
          state_d = ST_DUP;
        end else if (scan_last && !next_pass) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_DUP: begin
        if (dup_end || dup_eq) begin
          state_d = (scan_last && !next_pass) ? ST_FIN : ST_RD;
        end
      end
      ST_FIN:  state_d = (total_q == '0) ? ST_IDLE : ST_ORD;
      ST_ORD:  state_d = ST_OLD;
      ST_OLD:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (out_valid_q) begin
      state_d = state_q;
      if (res_acc) begin
        state_d = o_last_q ? ST_IDLE : ST_ORD;
      end
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    req_i.ready = (state_q == ST_IDLE) && !out_valid_q;
    mem_re      = (state_q == ST_RD) || (state_q == ST_ORD && !out_valid_q);
    mem_raddr   = (state_q == ST_RD) ? fi_q : hl_idx[k_q[HW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.req_type == REQ_LOAD && load_ok) begin
      mem[count_q[IW-1:0]] <= '{base_peak: req_i.feat_base_peak,
                                mono:      req_i.feat_mono_mass,
                                charge:    req_i.feat_charge,
                                first_rt:  req_i.feat_first_rt,
                                last_rt:   req_i.feat_last_rt,
                                apex_rt:   req_i.feat_apex_rt,
                                apex_int:  req_i.feat_apex_intensity,
                                total_int: req_i.feat_total_intensity};
    end
    if (mem_re) begin
      feat_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DUP && ((dup_end && total_q < HCW'(MAX_HITS)) ||
        (!dup_end && dup_eq && hl_apex[k_q[HW-1:0]] < feat_q.apex_int))) begin
      hl_idx[k_q[HW-1:0]]  <= fi_q;
      hl_chg[k_q[HW-1:0]]  <= feat_q.charge;
      hl_key[k_q[HW-1:0]]  <= key;
      hl_apex[k_q[HW-1:0]] <= feat_q.apex_int;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN) begin
      o_idx_q  <= '0;
      o_chg_q  <= '0;
      o_mh_q   <= '0;
      o_apex_q <= '0;
      o_tot_q  <= '0;
      o_last_q <= 1'b1;
    end else if (state_q == ST_OLD && !out_valid_q) begin
      o_idx_q  <= 10'(32'(hl_idx[k_q[HW-1:0]]));
      o_chg_q  <= feat_q.charge;
      o_mh_q   <= mh_full[30] ? MASS_MAX : mh_full[29:0];
      o_apex_q <= feat_q.apex_rt;
      o_tot_q  <= feat_q.total_int;
      o_last_q <= ((k_q + HCW'(1)) == total_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ppm_q         <= 10'd10;
      rt_tol_q      <= 16'd500;
      prec_only_q   <= 1'b0;
      max_persist_q <= 20'd2000;
      min_mass_q    <= 30'd39321600;
      max_mass_q    <= 30'd524288000;
      count_q       <= '0;
      fi_q          <= '0;
      pass_q        <= 1'b0;
      k_q           <= '0;
      total_q       <= '0;
      ovf_q         <= 1'b0;
      scan_mz_q     <= '0;
      scan_rt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PPM:         ppm_q         <= cfg_data_i[9:0];
          CFG_RT_TOL:      rt_tol_q      <= cfg_data_i[15:0];
          CFG_PREC_ONLY:   prec_only_q   <= cfg_data_i[0];
          CFG_MAX_PERSIST: max_persist_q <= cfg_data_i[19:0];
          CFG_MIN_MASS:    min_mass_q    <= cfg_data_i[29:0];
          CFG_MAX_MASS:    max_mass_q    <= cfg_data_i[29:0];
          default: ;
        endcase
      end
      if (req_acc) begin
        case (req_i.req_type)
          REQ_CLEAR: count_q <= '0;
          REQ_LOAD:  if (load_ok) count_q <= count_q + CW'(1);
          REQ_QUERY: begin
            scan_mz_q <= req_i.scan_mz;
            scan_rt_q <= req_i.scan_rt;
            fi_q      <= '0;
            pass_q    <= 1'b0;
            total_q   <= '0;
            ovf_q     <= 1'b0;
          end
          default: ;
        endcase
      end
      case (state_q)
        ST_CMP: begin
          k_q <= '0;
          if (!hit) begin
            if (scan_last) begin
              fi_q   <= '0;
              pass_q <= 1'b1;
            end else begin
              fi_q <= fi_q + IW'(1);
            end
          end
        end
        ST_DUP: begin
          if (dup_end || dup_eq) begin
            if (dup_end) begin
              if (total_q < HCW'(MAX_HITS)) begin
                total_q <= total_q + HCW'(1);
              end else begin
                ovf_q <= 1'b1;
              end
            end
            if (scan_last) begin
              fi_q   <= '0;
              pass_q <= 1'b1;
            end else begin
              fi_q <= fi_q + IW'(1);
            end
          end else begin
            k_q <= k_q + HCW'(1);
          end
        end
        ST_FIN: begin
          k_q <= '0;
          if (total_q == '0) begin
            out_valid_q <= 1'b1;
          end
        end
        ST_OLD: out_valid_q <= 1'b1;
        default: ;
      endcase
      if (res_acc) begin
        out_valid_q <= 1'b0;
        if (!o_last_q) begin
          k_q <= k_q + HCW'(1);
        end
      end
    end
  end

  assign res_o.valid               = out_valid_q;
  assign res_o.hit_index           = o_idx_q;
  assign res_o.hit_charge          = o_chg_q;
  assign res_o.hit_mh_mass         = o_mh_q;
  assign res_o.hit_apex_rt         = o_apex_q;
  assign res_o.hit_total_intensity = o_tot_q;
  assign res_o.hit_count           = 5'(32'(total_q));
  assign res_o.overflow            = ovf_q;
  assign res_o.last                = o_last_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= HCW'(MAX_HITS)) else $error("hit total beyond capacity");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH)) else $error("feature count beyond table depth");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !req_i.ready) else $error("request taken while busy");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_last_q && total_q != '0) |-> ((k_q + HCW'(1)) == total_q))
    else $error("last flag on wrong hit");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (total_q == HCW'(MAX_HITS))) else $error("overflow before list full");

endmodule

// ===== rtl/pfm_match_unit.sv =====
module pfm_match_unit (
  input  logic                clk_i,
  input  logic                en_i,
  input  pfm_pkg::feat_t      feat_i,
  input  logic [29:0]         mz_i,
  input  logic [19:0]         rt_i,
  input  pfm_pkg::match_cfg_t cfg_i,
  output logic                base_hit_o,
  output logic                wide_hit_o,
  output logic [pfm_pkg::KEY_W-1:0] key_o
);
  import pfm_pkg::*;

  logic [49:0] dmul_q, dmul_d;
  logic [39:0] tmul_q, tmul_d;
  logic [33:0] lhs_q, lhs_d;
  logic [30:0] lo_q, lo_d, hi_q, hi_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic        rt_hit_q, rt_hit_d;
  logic        znz_q, znz_d;
  logic [29:0] diff;
  logic [30:0] mh;
  logic [37:0] kprod;

  always_comb begin
    diff     = (feat_i.base_peak >= mz_i) ? feat_i.base_peak - mz_i
                                          : mz_i - feat_i.base_peak;
    dmul_d   = 50'(diff) * 50'd1000000;
    tmul_d   = 40'(cfg_i.ppm) * 40'(mz_i);
    lhs_d    = 34'(mz_i) * 34'(feat_i.charge);
    lo_d     = 31'(feat_i.mono) + 31'(lo_off(feat_i.charge));
    hi_d     = 31'(feat_i.mono) + 31'(hi_off(feat_i.charge));
    znz_d    = (feat_i.charge != 4'd0);
    // Time window compared with the margin moved to the other side.
    rt_hit_d = ((21'(rt_i) + 21'(cfg_i.rt_tol)) > 21'(feat_i.first_rt)) &&
               (21'(rt_i) < (21'(feat_i.last_rt) + 21'(cfg_i.rt_tol)));
    mh       = 31'(feat_i.mono) + 31'(PROTON_FX);
    kprod    = 38'(mh) * 38'd100 + 38'd32768;
    key_d    = kprod[16 +: KEY_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmul_q   <= dmul_d;
      tmul_q   <= tmul_d;
      lhs_q    <= lhs_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      key_q    <= key_d;
      rt_hit_q <= rt_hit_d;
      znz_q    <= znz_d;
    end
  end

  assign base_hit_o = rt_hit_q && (dmul_q < 50'(tmul_q));
  assign wide_hit_o = rt_hit_q && znz_q && (lhs_q > 34'(lo_q)) && (lhs_q < 34'(hi_q));
  assign key_o      = key_q;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfm_pkg::*;

  localparam int unsigned TDEPTH = 1024;
  localparam int unsigned HITCAP = 16;
  localparam longint PROTON = 66013;
  localparam longint W005 = 3277;
  localparam longint W210 = 137626;
  localparam longint W310 = 203162;

  typedef struct packed {
    req_e        kind;
    logic [29:0] bp;
    logic [29:0] mono;
    logic [3:0]  z;
    logic [19:0] first_rt;
    logic [19:0] last_rt;
    logic [19:0] apex_rt;
    logic [31:0] apex_int;
    logic [31:0] total_int;
    logic [29:0] mz;
    logic [19:0] srt;
  } item_t;

  typedef struct packed {
    logic [9:0]  idx;
    logic [3:0]  z;
    logic [29:0] mh;
    logic [19:0] apex_rt;
    logic [31:0] total_int;
    logic [4:0]  cnt;
    logic        ovf;
    logic        last;
  } hit_t;

  typedef struct packed {
    item_t r;
    logic  typed;
    hit_t  h;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  pfm_req_if req_if();
  pfm_res_if res_if();

  precursor_feature_matcher_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the matcher: stored features and configuration.
  feat_t       shadow_tab [TDEPTH];
  int unsigned shadow_cnt;
  logic [9:0]  m_ppm;
  logic [15:0] m_rt_tol;
  logic        m_prec_only;
  logic [19:0] m_persist;
  logic [29:0] m_min_mass;
  logic [29:0] m_max_mass;

  hit_t pending_hits [$];
  int   errs = 0;
  bit   idling = 1'b1;

  function automatic longint mass_key(logic [29:0] mono);
    return ((longint'(mono) + PROTON) * 100 + 32768) >>> 16;
  endfunction

  function automatic bit in_rt(feat_t f, longint rt);
    return rt > longint'(f.first_rt) - longint'(m_rt_tol) &&
           rt < longint'(f.last_rt) + longint'(m_rt_tol);
  endfunction

  function automatic bit near_base(feat_t f, longint mz);
    longint d;
    d = longint'(f.base_peak) >= mz ? longint'(f.base_peak) - mz : mz - longint'(f.base_peak);
    return d * 1000000 < longint'(m_ppm) * mz;
  endfunction

  function automatic bit in_wide(feat_t f, longint mz);
    longint z, m, hi;
    z = longint'(f.charge);
    m = longint'(f.mono);
    if (z == 0) return 1'b0;
    if (!(mz * z > m + z * (PROTON - W005))) return 1'b0;
    if (z == 1) hi = m + PROTON + W310;
    else if (z == 2) hi = m + 2 * PROTON + 2 * W210;
    else hi = m + z * PROTON + z * ((4 / z) * 65536 + W005);
    return mz * z < hi;
  endfunction

  // Merge a matched feature into the hit list, collapsing same charge and key.
  function automatic void note_hit(ref int unsigned hl[$], ref bit ovf, input int unsigned i);
    feat_t nf;
    nf = shadow_tab[i];
    foreach (hl[k]) begin
      if (shadow_tab[hl[k]].charge == nf.charge &&
          mass_key(shadow_tab[hl[k]].mono) == mass_key(nf.mono)) begin
        if (shadow_tab[hl[k]].apex_int < nf.apex_int) hl[k] = i;
        return;
      end
    end
    if (hl.size() >= HITCAP) ovf = 1'b1;
    else hl.insert(hl.size(), i);
  endfunction

  function automatic void apply_item(item_t r, bit push);
    int unsigned hl[$];
    bit ovf;
    feat_t f;
    hit_t h;
    longint mh;
    case (r.kind)
      REQ_CLEAR: shadow_cnt = 0;
      REQ_LOAD: begin
        f = '{base_peak: r.bp, mono: r.mono, charge: r.z, first_rt: r.first_rt,
              last_rt: r.last_rt, apex_rt: r.apex_rt, apex_int: r.apex_int,
              total_int: r.total_int};
        if (longint'(f.last_rt) - longint'(f.first_rt) <= longint'(m_persist) &&
            f.mono >= m_min_mass && f.mono <= m_max_mass && shadow_cnt < TDEPTH) begin
          shadow_tab[shadow_cnt] = f;
          shadow_cnt++;
        end
      end
      REQ_QUERY: begin
        ovf = 1'b0;
        for (int unsigned i = 0; i < shadow_cnt; i++)
          if (in_rt(shadow_tab[i], r.srt) && near_base(shadow_tab[i], r.mz))
            note_hit(hl, ovf, i);
        if (!m_prec_only)
          for (int unsigned i = 0; i < shadow_cnt; i++)
            if (in_rt(shadow_tab[i], r.srt) && in_wide(shadow_tab[i], r.mz))
              note_hit(hl, ovf, i);
        if (!push) return;
        if (hl.size() == 0) begin
          h = '0;
          h.last = 1'b1;
          pending_hits.insert(pending_hits.size(), h);
        end
        foreach (hl[k]) begin
          f = shadow_tab[hl[k]];
          mh = longint'(f.mono) + PROTON;
          if (mh > longint'(MASS_MAX)) mh = longint'(MASS_MAX);
          h.idx = hl[k][9:0];
          h.z = f.charge;
          h.mh = mh[29:0];
          h.apex_rt = f.apex_rt;
          h.total_int = f.total_int;
          h.cnt = 5'(hl.size());
          h.ovf = ovf;
          h.last = (k == hl.size() - 1);
          pending_hits.insert(pending_hits.size(), h);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void chk(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errs++;
      $display("%0t: %s expected %0h got %0h", $time, name, e, a);
    end
  endfunction

  // Result side: random stalls while idling is set, and every taken item is checked in order.
  always @(posedge clk_i) begin
    hit_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_hits.size() == 0) begin
        errs++;
        $display("%0t: unexpected result item, index %0h", $time, res_if.hit_index);
      end else begin
        e = pending_hits.pop_front();
        chk("hit_index", 32'(e.idx), 32'(res_if.hit_index));
        chk("hit_charge", 32'(e.z), 32'(res_if.hit_charge));
        chk("hit_mh_mass", 32'(e.mh), 32'(res_if.hit_mh_mass));
        chk("hit_apex_rt", 32'(e.apex_rt), 32'(res_if.hit_apex_rt));
        chk("hit_total_intensity", e.total_int, res_if.hit_total_intensity);
        chk("hit_count", 32'(e.cnt), 32'(res_if.hit_count));
        chk("overflow", 32'(e.ovf), 32'(res_if.overflow));
        chk("last", 32'(e.last), 32'(res_if.last));
      end
    end
    res_if.ready <= idling ? ($urandom_range(99) >= 35) : 1'b1;
  end

  task automatic send(item_t r, bit typed = 1'b0, hit_t h = '0);
    req_if.valid <= 1'b1;
    req_if.req_type <= r.kind;
    req_if.feat_base_peak <= r.bp;
    req_if.feat_mono_mass <= r.mono;
    req_if.feat_charge <= r.z;
    req_if.feat_first_rt <= r.first_rt;
    req_if.feat_last_rt <= r.last_rt;
    req_if.feat_apex_rt <= r.apex_rt;
    req_if.feat_apex_intensity <= r.apex_int;
    req_if.feat_total_intensity <= r.total_int;
    req_if.scan_mz <= r.mz;
    req_if.scan_rt <= r.srt;
    do @(posedge clk_i); while (!req_if.ready);
    apply_item(r, !typed);
    if (typed) pending_hits.insert(pending_hits.size(), h);
    if (idling && $urandom_range(99) < 35) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Hold requests until every result is back, then let the block settle.
  task automatic drain();
    req_if.valid <= 1'b0;
    wait (pending_hits.size() == 0);
    @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [29:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PPM:         m_ppm = v[9:0];
      CFG_RT_TOL:      m_rt_tol = v[15:0];
      CFG_PREC_ONLY:   m_prec_only = v[0];
      CFG_MAX_PERSIST: m_persist = v[19:0];
      CFG_MIN_MASS:    m_min_mass = v;
      CFG_MAX_MASS:    m_max_mass = v;
      default: ;
    endcase
  endtask

  function automatic item_t rand_item();
    item_t r;
    r = '{kind: req_e'($urandom_range(3)), bp: 30'($urandom), mono: 30'($urandom),
          z: 4'($urandom), first_rt: 20'($urandom), last_rt: 20'($urandom),
          apex_rt: 20'($urandom), apex_int: $urandom, total_int: $urandom,
          mz: 30'($urandom), srt: 20'($urandom)};
    return r;
  endfunction

  // A well-formed feature: for a non-zero charge, base peak sits on the charge envelope of its mass.
  function automatic item_t make_feat(logic [29:0] mono, logic [3:0] z);
    item_t r;
    int unsigned dur;
    r = rand_item();
    r.kind = REQ_LOAD;
    r.mono = mono;
    r.z = z;
    if (z != 0) r.bp = 30'(longint'(mono) / z + PROTON + $urandom_range(0, 400));
    dur = $urandom_range(0, 2500);
    r.first_rt = 20'($urandom_range(0, 1000000));
    r.last_rt = 20'(r.first_rt + dur);
    r.apex_rt = 20'(r.first_rt + dur / 2);
    return r;
  endfunction

  function automatic item_t make_query(item_t f);
    item_t q;
    int unsigned pick;
    q = rand_item();
    q.kind = REQ_QUERY;
    pick = $urandom_range(3);
    if (pick == 0 || f.z == 0)
      q.mz = 30'(longint'(f.bp) + $urandom_range(0, 4000) - 2000);
    else if (pick == 1)
      q.mz = 30'(longint'(f.mono) / f.z + PROTON - 4000 + $urandom_range(0, 250000));
    else if (pick == 2)
      q.mz = f.bp;
    q.srt = 20'(longint'(f.first_rt) - m_rt_tol - 100 +
                $urandom_range(0, f.last_rt - f.first_rt + 2 * m_rt_tol + 200));
    return q;
  endfunction

  function automatic logic [29:0] pick_mass();
    if (m_min_mass <= m_max_mass) return 30'($urandom_range(m_max_mass, m_min_mass));
    return 30'($urandom);
  endfunction

  // Clear, load a cluster of features with some near-duplicates, then query it.
  task automatic cluster_run(ref int n);
    item_t feats [$];
    item_t f, c;
    int unsigned nl;
    c = rand_item();
    c.kind = REQ_CLEAR;
    send(c);
    nl = $urandom_range(1, 8);
    for (int i = 0; i < nl; i++) begin
      if (feats.size() != 0 && $urandom_range(2) == 0) begin
        f = feats[$urandom_range(feats.size() - 1)];
        f.mono = 30'(f.mono + $urandom_range(0, 400));
        f.apex_int = $urandom;
        f.total_int = $urandom;
      end else begin
        f = make_feat(pick_mass(), 4'($urandom_range(0, 10) == 10 ? $urandom_range(10, 15)
                                                                 : $urandom_range(0, 9)));
      end
      feats.insert(feats.size(), f);
      send(f);
      n++;
    end
    repeat ($urandom_range(1, 4)) begin
      send($urandom_range(9) == 0 ? rand_item() : make_query(feats[$urandom_range(nl - 1)]));
      n++;
    end
  endtask

  // More distinct hits than the list holds: same base peak, spread masses.
  task automatic overflow_run();
    item_t f, q;
    logic [29:0] m0;
    q = '0;
    q.kind = REQ_CLEAR;
    send(q);
    m0 = pick_mass();
    for (int i = 0; i < 20; i++) begin
      f = make_feat(30'(m0 + i * 2000), 4'd1);
      f.bp = 30'(m0 + PROTON);
      f.first_rt = 20'd10000;
      f.last_rt = 20'd10000;
      send(f);
    end
    q.kind = REQ_QUERY;
    q.mz = 30'(m0 + PROTON);
    q.srt = 20'd10000;
    send(q);
  endtask

  row_t dir_rows [$];

  task automatic build_rows();
    row_t w;
    hit_t none;
    none = '0;
    none.last = 1'b1;
    w = '0;
    w.r.kind = REQ_QUERY; w.typed = 1'b1; w.h = none;
    dir_rows.insert(dir_rows.size(), w);
    w = '0;
    w.r = '{REQ_LOAD, 30'd39387613, 30'd39321600, 4'd1, 20'd1000, 20'd1500, 20'd1200,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 30'd0, 20'd0};
    dir_rows.insert(dir_rows.size(), w);
    w.r = '{REQ_LOAD, 30'd262210013, 30'd524288000, 4'd2, 20'd0, 20'd2000, 20'd1000,
            32'd0, 32'd0, 30'h3FFF_FFFF, 20'hFFFFF};
    dir_rows.insert(dir_rows.size(), w);
    w.r.mono = 30'd39321599;
    dir_rows.insert(dir_rows.size(), w);
    w.r = '{REQ_LOAD, 30'd33399346, 30'd100000000, 4'd3, 20'd5000, 20'd100, 20'd3000,
            32'd5, 32'd77, 30'd0, 20'd0};
    dir_rows.insert(dir_rows.size(), w);
    w.r.first_rt = 20'd0; w.r.last_rt = 20'd2001;
    dir_rows.insert(dir_rows.size(), w);
    w.r = '{REQ_LOAD, 30'd80066013, 30'd80000000, 4'd0, 20'd0, 20'd2000, 20'd900,
            32'd9, 32'd10, 30'd0, 20'd0};
    dir_rows.insert(dir_rows.size(), w);
    w.r.z = 4'd15; w.r.bp = 30'd5400000;
    dir_rows.insert(dir_rows.size(), w);
    w.r = '0; w.r.kind = REQ_QUERY;
    w.r.mz = 30'd39387613; w.r.srt = 20'd1200;
    dir_rows.insert(dir_rows.size(), w);
    w.r.mz = 30'd262210013; w.r.srt = 20'd1000;
    dir_rows.insert(dir_rows.size(), w);
    w.r.mz = 30'd0;
    dir_rows.insert(dir_rows.size(), w);
    w.r.mz = 30'd33400000; w.r.srt = 20'd2000;
    dir_rows.insert(dir_rows.size(), w);
    w.r.mz = 30'd80066013; w.r.srt = 20'd1000;
    dir_rows.insert(dir_rows.size(), w);
    w.r.mz = 30'd5399000;
    dir_rows.insert(dir_rows.size(), w);
    w.r = rand_item(); w.r.kind = REQ_NONE;
    dir_rows.insert(dir_rows.size(), w);
    w.r = '0; w.r.kind = REQ_QUERY; w.r.mz = 30'h3FFF_FFFF; w.r.srt = 20'hFFFFF;
    w.typed = 1'b1; w.h = none;
    dir_rows.insert(dir_rows.size(), w);
    w.r = '0; w.r.kind = REQ_CLEAR; w.typed = 1'b0;
    dir_rows.insert(dir_rows.size(), w);
    w.r.kind = REQ_QUERY; w.r.mz = 30'd80066013; w.r.srt = 20'd1000;
    w.typed = 1'b1; w.h = none;
    dir_rows.insert(dir_rows.size(), w);
  endtask

  initial begin
    int n;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_CLEAR;
    req_if.feat_base_peak = '0;
    req_if.feat_mono_mass = '0;
    req_if.feat_charge = '0;
    req_if.feat_first_rt = '0;
    req_if.feat_last_rt = '0;
    req_if.feat_apex_rt = '0;
    req_if.feat_apex_intensity = '0;
    req_if.feat_total_intensity = '0;
    req_if.scan_mz = '0;
    req_if.scan_rt = '0;
    res_if.ready = 1'b0;
    shadow_cnt = 0;
    m_ppm = 10'd10;
    m_rt_tol = 16'd500;
    m_prec_only = 1'b0;
    m_persist = 20'd2000;
    m_min_mass = 30'd39321600;
    m_max_mass = 30'd524288000;
    build_rows();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].h);

    // Each phase sets every register; the first two use the extremes.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      idling = (ph != 2);
      write_reg(CFG_PPM, ph == 0 ? 30'd1000 : ph == 1 ? 30'd0 : 30'($urandom_range(1, 1000)));
      write_reg(CFG_RT_TOL, ph == 0 ? 30'd60000 : ph == 1 ? 30'd0 :
                            30'($urandom_range(0, 65535)));
      write_reg(CFG_PREC_ONLY, 30'(ph % 2));
      write_reg(CFG_MAX_PERSIST, ph == 0 ? 30'hFFFFF : ph == 1 ? 30'd0 :
                                 30'($urandom_range(0, 3000)));
      write_reg(CFG_MIN_MASS, ph == 0 ? 30'd0 : ph == 1 ? 30'h3FFF_FFF0 :
                              30'($urandom_range(0, 50000000)));
      write_reg(CFG_MAX_MASS, ph == 0 || ph == 1 ? 30'h3FFF_FFFF :
                              30'($urandom_range(400000000, 30'h3FFF_FFFF)));
      n = 0;
      if (ph == 0 || ph == 3) overflow_run();
      while (n < 18) cluster_run(n);
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (errs == 0 && pending_hits.size() == 0)
      $display("[precursor_feature_matcher_core] OK");
    else
      $display("[precursor_feature_matcher_core] ERROR");
    $finish;
  end

  initial begin
    #50ms;
    $display("[precursor_feature_matcher_core] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pfm_pkg.sv
rtl/pfm_if.sv
rtl/pfm_match_unit.sv
rtl/precursor_feature_matcher_core.sv
tb/tb_top.sv
